### hdl/spq_pkg.sv
// Shared types, widths and codes for the sorted priority queue.
// Used by spq_cell, spq_seq and sorted_priority_queue_top; depends on nothing.
`timescale 1ns / 1ps

package spq_pkg;

	// Default number of queue entries.
	localparam int DEPTH_DEF = 16;

	// Word field widths.
	localparam int ACTION_W = 2;
	localparam int VALUE_W  = 32;
	localparam int PRIO_W   = 7;
	localparam int STATUS_W = 2;

	// Action codes of an input word.
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

	// Status codes of a result word.
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

	// One stored entry.
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]         prio;
	} entry_t;

	// Commands broadcast from the sequencer to every cell.
	typedef struct packed {
		logic ins;
		logic del;
		logic rot;
	} cell_cmd_t;

endpackage

### hdl/spq_cell.sv
// One cell of the sorted queue chain: holds a single entry and decides locally
// whether to take the new word or a neighbor's entry. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF,
	parameter int INDEX = 0,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  spq_pkg::cell_cmd_t cmd,
	input  logic [CNT_W-1:0]   count,
	input  spq_pkg::entry_t    new_ent,
	input  spq_pkg::entry_t    left_ent,
	input  spq_pkg::entry_t    right_ent,
	input  spq_pkg::entry_t    head_ent,
	input  logic               left_open,
	input  logic               left_hit,
	output spq_pkg::entry_t    ent,
	output logic               open,
	output logic               hit
);
	import spq_pkg::*;

	localparam logic [CNT_W-1:0] IDX    = CNT_W'(INDEX);
	localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(INDEX + 1);

	entry_t ent_q;
	logic   valid;
	logic   match;
	logic   wrap;

	// The cell is occupied when its place lies below the fill count.
	assign valid = IDX < count;

	// An open cell is empty or holds a strictly higher priority than the new word.
	assign open  = !valid || (ent_q.prio > new_ent.prio);

	// Delete search: a hit anywhere at or before this cell shifts it.
	assign match = valid && (ent_q.value == new_ent.value);
	assign hit   = left_hit || match;

	// The last occupied cell takes the head entry during a read-out rotation.
	assign wrap  = (IDX_P1 == count);

	// Entry register; the first open cell takes the new word, later ones shift down.
	always_ff @(posedge clk) begin
		if (cmd.ins && open) begin
			ent_q <= left_open ? left_ent : new_ent;
		end else if (cmd.del && hit) begin
			ent_q <= right_ent;
		end else if (cmd.rot) begin
			ent_q <= wrap ? head_ent : right_ent;
		end
	end

	assign ent = ent_q;

endmodule

### hdl/spq_seq.sv
// Sequencer of the sorted queue: fill count, read-out walk and result register.
// Depends on spq_pkg; drives the command struct of every spq_cell.
`timescale 1ns / 1ps

module spq_seq #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [spq_pkg::ACTION_W-1:0]    action,
	input  logic                            hit_any,
	input  spq_pkg::entry_t                 head_ent,
	output spq_pkg::cell_cmd_t              cmd,
	output logic [CNT_W-1:0]                count,
	output logic                            busy,
	output logic                            done,
	output logic [spq_pkg::STATUS_W-1:0]    status,
	output logic signed [spq_pkg::VALUE_W-1:0] out_value,
	output logic [spq_pkg::PRIO_W-1:0]      out_priority,
	output logic                            last
);
	import spq_pkg::*;

	localparam logic SQ_IDLE = 1'b0;
	localparam logic SQ_READ = 1'b1;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

	logic                  state_q;
	logic                  state_d;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      idx_d;
	logic                  done_q;
	logic                  done_d;
	logic [STATUS_W-1:0]   status_q;
	logic [STATUS_W-1:0]   status_d;
	entry_t                res_q;
	entry_t                res_d;
	logic                  last_q;
	logic                  last_d;
	logic                  accept;
	logic                  full;
	logic                  read_last;

	assign busy      = (state_q == SQ_READ);
	assign accept    = start && !busy;
	assign full      = (count_q == FULL_CNT);
	assign read_last = (idx_q == (count_q - ONE));

	// Commands to the cell row.
	assign cmd.ins = accept && (action == ACT_INSERT) && !full;
	assign cmd.del = accept && (action == ACT_DELETE) && hit_any;
	assign cmd.rot = busy;

	// Next state and next result word.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		done_d   = 1'b0;
		status_d = ST_OK;
		res_d    = '0;
		last_d   = 1'b1;
		if (accept) begin
			case (action)
				ACT_INSERT: begin
					done_d   = 1'b1;
					status_d = full ? ST_FULL : ST_OK;
					if (!full) begin
						count_d = count_q + ONE;
					end
				end
				ACT_DELETE: begin
					done_d   = 1'b1;
					status_d = hit_any ? ST_OK : ST_NOTFOUND;
					if (hit_any) begin
						count_d = count_q - ONE;
					end
				end
				ACT_READ: begin
					if (count_q == '0) begin
						done_d   = 1'b1;
						status_d = ST_EMPTY;
					end else begin
						state_d = SQ_READ;
						idx_d   = '0;
					end
				end
				default: begin
					done_d = 1'b0;
				end
			endcase
		end else if (busy) begin
			// Emit the head and rotate the row by one place.
			done_d = 1'b1;
			res_d  = head_ent;
			last_d = read_last;
			idx_d  = idx_q + ONE;
			if (read_last) begin
				state_d = SQ_IDLE;
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			done_q  <= done_d;
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		status_q <= status_d;
		res_q    <= res_d;
		last_q   <= last_d;
	end

	assign count        = count_q;
	assign done         = done_q;
	assign status       = status_q;
	assign out_value    = res_q.value;
	assign out_priority = res_q.prio;
	assign last         = last_q;

endmodule

### hdl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: a row of spq_cell plus the spq_seq
// sequencer. Depends on spq_pkg, spq_cell and spq_seq.
`timescale 1ns / 1ps

// A word is taken at a clock edge where start is high and busy is low. Insert
// and delete finish at that edge in the cell row, which compares all entries in
// parallel, and their single result word shows on the next cycle with done high.
// A read-all of N entries keeps busy high while the row rotates by one place
// per cycle, giving one result word per cycle with last on the final one; an
// empty queue gives one empty-status word on the next cycle. Each result
// is valid for exactly one cycle while done is high, and the receiver cannot
// stall it, so it must take every word as it comes.
module sorted_priority_queue_top #(
	parameter int QUEUE_DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [spq_pkg::ACTION_W-1:0]       action,
	input  logic signed [spq_pkg::VALUE_W-1:0] item_value,
	input  logic [spq_pkg::PRIO_W-1:0]         item_priority,
	output logic                               done,
	output logic [spq_pkg::STATUS_W-1:0]       status,
	output logic signed [spq_pkg::VALUE_W-1:0] out_value,
	output logic [spq_pkg::PRIO_W-1:0]         out_priority,
	output logic                               last
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cell_cmd_t        cmd;
	logic [CNT_W-1:0] count;
	entry_t           new_ent;
	entry_t           ents  [QUEUE_DEPTH];
	logic             opens [QUEUE_DEPTH];
	logic             hits  [QUEUE_DEPTH];

	assign new_ent.value = item_value;
	assign new_ent.prio  = item_priority;

	// Row of cells; open and hit ripple from the head toward the tail.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_o;
		logic   left_h;

		if (i == 0) begin : g_head
			assign left_e = new_ent;
			assign left_o = 1'b0;
			assign left_h = 1'b0;
		end else begin : g_body
			assign left_e = ents[i-1];
			assign left_o = opens[i-1];
			assign left_h = hits[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = ents[i];
		end else begin : g_inner
			assign right_e = ents[i+1];
		end

		spq_cell #(
			.DEPTH (QUEUE_DEPTH),
			.INDEX (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.count     (count),
			.new_ent   (new_ent),
			.left_ent  (left_e),
			.right_ent (right_e),
			.head_ent  (ents[0]),
			.left_open (left_o),
			.left_hit  (left_h),
			.ent       (ents[i]),
			.open      (opens[i]),
			.hit       (hits[i])
		);
	end

	// Sequencer with fill count and result register.
	spq_seq #(
		.DEPTH (QUEUE_DEPTH)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.hit_any      (hits[QUEUE_DEPTH-1]),
		.head_ent     (ents[0]),
		.cmd          (cmd),
		.count        (count),
		.busy         (busy),
		.done         (done),
		.status       (status),
		.out_value    (out_value),
		.out_priority (out_priority),
		.last         (last)
	);

endmodule
